// ----- design/mstu_pkg.sv -----
// Shared constants and types for the multi-slot software timer.
`default_nettype none
package mstu_pkg;
  localparam int OP_W   = 3;
  localparam int SLOT_W = 4;
  localparam int VAL_W  = 32;
  localparam int KIND_W = 2;

  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_START    = 3'd1;
  localparam logic [OP_W-1:0] OP_CANCEL   = 3'd2;
  localparam logic [OP_W-1:0] OP_MODIFY   = 3'd3;
  localparam logic [OP_W-1:0] OP_DISPATCH = 3'd4;

  localparam logic [KIND_W-1:0] KIND_FIRE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WORK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_WRAP,
    ST_SCAN,
    ST_DECIDE,
    ST_FIRE,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

// ----- design/mstu_if.sv -----
// Request and response channel interfaces of the timer unit.
`default_nettype none
interface mstu_req_if;
  logic                             valid;
  logic                             ready;
  logic [mstu_pkg::OP_W-1:0]        op;
  logic [mstu_pkg::SLOT_W-1:0]      slot;
  logic [mstu_pkg::VAL_W-1:0]       period_ticks;
  logic [mstu_pkg::VAL_W-1:0]       start_tick;
  logic                             repeat_req;
  logic                             stop_repeat;
  logic [mstu_pkg::VAL_W-1:0]       now_tick;
  logic [mstu_pkg::VAL_W-1:0]       work_tag;
  modport source (output valid, op, slot, period_ticks, start_tick, repeat_req,
                  stop_repeat, now_tick, work_tag, input ready);
  modport sink (input valid, op, slot, period_ticks, start_tick, repeat_req,
                stop_repeat, now_tick, work_tag, output ready);
endinterface

interface mstu_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [mstu_pkg::KIND_W-1:0]      kind;
  logic [mstu_pkg::SLOT_W-1:0]      fired_slot;
  logic [mstu_pkg::VAL_W-1:0]       dispatched_tag;
  logic [mstu_pkg::VAL_W-1:0]       next_delay;
  logic                             slot_active;
  logic                             last;
  modport source (output valid, kind, fired_slot, dispatched_tag, next_delay,
                  slot_active, last, input ready);
  modport sink (input valid, kind, fired_slot, dispatched_tag, next_delay,
                slot_active, last, output ready);
endinterface
`default_nettype wire

// ----- design/mstu_evq.sv -----
// Event list: fired slots and dispatches of one step, held until the step ends.
`default_nettype none
module mstu_evq #(
  parameter int DEPTH = 17,
  parameter int W     = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         clr,
  input  wire logic                         push,
  input  wire logic [W-1:0]                 push_data,
  input  wire logic [$clog2(DEPTH+1)-1:0]   rd_ptr,
  output logic      [W-1:0]                 rd_data,
  output logic      [$clog2(DEPTH+1)-1:0]   count
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [CW+AW-1:0] wr_x, rd_x;

  assign wr_x = {{AW{1'b0}}, count};
  assign rd_x = {{AW{1'b0}}, rd_ptr};

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      count <= '0;
    end else if (push) begin
      count <= count + CW'(1);
    end
    if (push) begin
      mem[wr_x[AW-1:0]] <= push_data;
    end
  end

  assign rd_data = mem[rd_x[AW-1:0]];
endmodule
`default_nettype wire

// ----- design/multi_slot_software_timer_unit.sv -----
// Multi-slot software timer: slot table, sequencer and serial deadline scanner.
// Usage: each request item carries the current tick and one command (tick,
// start, cancel, modify, dispatch). The unit applies the command, fires all
// slots of the old round when the tick wrapped, then fires due slots in
// deadline order (lower slot first on equal deadlines), and ends every step
// with a summary item (last = 1) giving the delay to the next deadline.
// Response items: one per fired slot or dispatch, then the summary.
// Timing: one request at a time; req.ready is high only while idle. A step
// runs one scan pass per slot that the scan fires plus one closing pass per
// phase (wrap phase only on a wrap), then emits its response items. A single
// compare unit walks the slots one per cycle and sets the length of each pass.
// The response sits in an output register; when the receiver stalls, the
// sequencer waits and no item is lost. Reset (rst, synchronous) clears all
// slots, the round bit and the previous tick; the unit is ready right after.
`default_nettype none
module multi_slot_software_timer_unit #(
  parameter int TIMER_SLOTS = 16,
  parameter int TICK_BITS   = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mstu_req_if.sink    req,
  mstu_rsp_if.source  rsp
);
  localparam int TW  = TICK_BITS;
  localparam int VW  = mstu_pkg::VAL_W;
  localparam int SLW = mstu_pkg::SLOT_W;
  localparam int SW  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int QD  = TIMER_SLOTS + 1;
  localparam int QCW = $clog2(QD + 1);
  localparam int QEW = SW + 1;

  mstu_pkg::state_t state, state_next;

  // slot table
  logic [TW-1:0]          deadline [TIMER_SLOTS];
  logic [TW-1:0]          period   [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] cyclic, active, armed, epoch, old;
  logic                   cur_epoch;
  logic [TW-1:0]          prev_now;

  // latched request
  logic [mstu_pkg::OP_W-1:0] op_r;
  logic [SLW-1:0]            slot_r;
  logic [TW-1:0]             per_r, st_r, now_r;
  logic                      rep_r, stop_r;
  logic [VW-1:0]             tag_r;

  // scanner
  logic [SW-1:0] idx, best;
  logic [TW-1:0] best_dl;
  logic          found, in_wrap;
  logic [TW-1:0] sum_delay;

  // event list
  logic [QCW-1:0] q_count, rd_ptr;
  logic [QEW-1:0] q_rd, q_wdata;
  logic           q_push, q_clr;

  // request field extension
  logic [VW+TW-1:0] per_x, st_x, now_x;
  assign per_x = {{TW{1'b0}}, req.period_ticks};
  assign st_x  = {{TW{1'b0}}, req.start_tick};
  assign now_x = {{TW{1'b0}}, req.now_tick};

  logic [SLW+SW-1:0] slot_x;
  logic [SW-1:0]     slot_i;
  logic              slot_ok;
  assign slot_x  = {{SW{1'b0}}, slot_r};
  assign slot_i  = slot_x[SW-1:0];
  assign slot_ok = int'(slot_r) < TIMER_SLOTS;

  // command arithmetic
  logic [TW-1:0] diff, arm_dl, re_dl;
  logic          fire_now, arm_ep, re_ep;
  assign diff     = (now_r >= st_r) ? now_r - st_r : st_r - now_r;
  assign fire_now = diff >= per_r;
  assign arm_dl   = (fire_now ? now_r : st_r) + per_r;
  assign arm_ep   = (arm_dl < now_r) ? ~cur_epoch : cur_epoch;
  assign re_dl    = now_r + period[best];
  assign re_ep    = (re_dl < now_r) ? ~cur_epoch : cur_epoch;

  // scan step
  logic cand, take, scan_last;
  assign cand      = in_wrap ? old[idx] : (armed[idx] && (epoch[idx] == cur_epoch));
  assign take      = cand && (!found || (deadline[idx] < best_dl));
  assign scan_last = idx == SW'(TIMER_SLOTS - 1);

  // response loading
  logic rsp_load, emit_sum, act;
  assign rsp_load = !rsp.valid || rsp.ready;
  assign emit_sum = rd_ptr >= q_count;
  assign act      = slot_ok && active[slot_i];

  logic [SW+SLW-1:0] fs_x;
  logic [VW+TW-1:0]  dl_x;
  assign fs_x = {{SLW{1'b0}}, q_rd[SW-1:0]};
  assign dl_x = {{VW{1'b0}}, sum_delay};

  assign req.ready = state == mstu_pkg::ST_IDLE;

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    q_wdata    = '0;
    q_clr      = 1'b0;
    case (state)
      mstu_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = mstu_pkg::ST_CMD;
          q_clr      = 1'b1;
        end
      end
      mstu_pkg::ST_CMD: begin
        state_next = mstu_pkg::ST_WRAP;
        if (op_r == mstu_pkg::OP_START && slot_ok && fire_now) begin
          q_push  = 1'b1;
          q_wdata = {1'b0, slot_i};
        end else if (op_r == mstu_pkg::OP_DISPATCH) begin
          q_push  = 1'b1;
          q_wdata = {1'b1, {SW{1'b0}}};
        end
      end
      mstu_pkg::ST_WRAP: state_next = mstu_pkg::ST_SCAN;
      mstu_pkg::ST_SCAN: begin
        if (scan_last) state_next = mstu_pkg::ST_DECIDE;
      end
      mstu_pkg::ST_DECIDE: begin
        if (in_wrap) begin
          state_next = found ? mstu_pkg::ST_FIRE : mstu_pkg::ST_SCAN;
        end else if (found && best_dl <= now_r) begin
          state_next = mstu_pkg::ST_FIRE;
        end else begin
          state_next = mstu_pkg::ST_EMIT;
        end
      end
      mstu_pkg::ST_FIRE: begin
        state_next = mstu_pkg::ST_SCAN;
        q_push     = 1'b1;
        q_wdata    = {1'b0, best};
      end
      mstu_pkg::ST_EMIT: begin
        if (rsp_load && emit_sum) state_next = mstu_pkg::ST_IDLE;
      end
      default: state_next = mstu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mstu_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cyclic    <= '0;
      active    <= '0;
      armed     <= '0;
      epoch     <= '0;
      old       <= '0;
      cur_epoch <= 1'b0;
      prev_now  <= '0;
      in_wrap   <= 1'b0;
      found     <= 1'b0;
      idx       <= '0;
      rd_ptr    <= '0;
    end else begin
      case (state)
        mstu_pkg::ST_IDLE: begin
          if (req.valid) begin
            op_r   <= req.op;
            slot_r <= req.slot;
            per_r  <= (per_x[TW-1:0] == '0) ? TW'(1) : per_x[TW-1:0];
            st_r   <= st_x[TW-1:0];
            now_r  <= now_x[TW-1:0];
            rep_r  <= req.repeat_req;
            stop_r <= req.stop_repeat;
            tag_r  <= req.work_tag;
          end
        end
        mstu_pkg::ST_CMD: begin
          if (slot_ok) begin
            case (op_r)
              mstu_pkg::OP_START: begin
                period[slot_i]   <= per_r;
                cyclic[slot_i]   <= rep_r;
                deadline[slot_i] <= arm_dl;
                epoch[slot_i]    <= arm_ep;
                armed[slot_i]    <= !(fire_now && !rep_r);
                active[slot_i]   <= !(fire_now && !rep_r);
              end
              mstu_pkg::OP_CANCEL: begin
                if (armed[slot_i]) begin
                  armed[slot_i]  <= 1'b0;
                  active[slot_i] <= 1'b0;
                end
              end
              mstu_pkg::OP_MODIFY: begin
                if (stop_r) cyclic[slot_i] <= 1'b0;
                else        period[slot_i] <= per_r;
              end
              default: ;
            endcase
          end
        end
        mstu_pkg::ST_WRAP: begin
          // tick wrapped: the current round becomes the old one
          if (now_r < prev_now) begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
              old[i] <= armed[i] && (epoch[i] == cur_epoch);
            end
            cur_epoch <= ~cur_epoch;
            in_wrap   <= 1'b1;
          end else begin
            in_wrap <= 1'b0;
          end
          prev_now <= now_r;
          found    <= 1'b0;
          idx      <= '0;
        end
        mstu_pkg::ST_SCAN: begin
          if (take) begin
            found   <= 1'b1;
            best    <= idx;
            best_dl <= deadline[idx];
          end
          if (!scan_last) idx <= idx + SW'(1);
        end
        mstu_pkg::ST_DECIDE: begin
          if (in_wrap && !found) in_wrap <= 1'b0;
          sum_delay <= found ? best_dl - now_r : '0 - now_r;
          found     <= 1'b0;
          idx       <= '0;
          rd_ptr    <= '0;
        end
        mstu_pkg::ST_FIRE: begin
          if (in_wrap) old[best] <= 1'b0;
          if (cyclic[best]) begin
            deadline[best] <= re_dl;
            epoch[best]    <= re_ep;
            armed[best]    <= 1'b1;
          end else begin
            armed[best]  <= 1'b0;
            active[best] <= 1'b0;
          end
        end
        mstu_pkg::ST_EMIT: begin
          if (rsp_load && !emit_sum) rd_ptr <= rd_ptr + QCW'(1);
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == mstu_pkg::ST_EMIT && rsp_load) begin
      rsp.valid       <= 1'b1;
      rsp.slot_active <= act;
      if (emit_sum) begin
        rsp.kind           <= mstu_pkg::KIND_SUMMARY;
        rsp.fired_slot     <= '0;
        rsp.dispatched_tag <= '0;
        rsp.next_delay     <= dl_x[VW-1:0];
        rsp.last           <= 1'b1;
      end else begin
        rsp.kind           <= q_rd[QEW-1] ? mstu_pkg::KIND_WORK : mstu_pkg::KIND_FIRE;
        rsp.fired_slot     <= q_rd[QEW-1] ? '0 : fs_x[SLW-1:0];
        rsp.dispatched_tag <= q_rd[QEW-1] ? tag_r : '0;
        rsp.next_delay     <= '0;
        rsp.last           <= 1'b0;
      end
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  mstu_evq #(.DEPTH(QD), .W(QEW)) u_evq (
    .clk       (clk),
    .rst       (rst),
    .clr       (q_clr),
    .push      (q_push),
    .push_data (q_wdata),
    .rd_ptr    (rd_ptr),
    .rd_data   (q_rd),
    .count     (q_count)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (rst) q_count <= QCW'(QD))
    else $error("event list overflow");
  a_fire_found: assert property (@(posedge clk) disable iff (rst)
    (state == mstu_pkg::ST_DECIDE && state_next == mstu_pkg::ST_FIRE) |-> found)
    else $error("fire without a selected slot");
  a_sum_out: assert property (@(posedge clk) disable iff (rst)
    (state == mstu_pkg::ST_EMIT && rsp_load && emit_sum) |=> (rsp.valid && rsp.last))
    else $error("summary item not presented");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == mstu_pkg::ST_FIRE) |=> !req.ready)
    else $error("request taken during a step");
endmodule
`default_nettype wire

// ----- sim/multi_slot_software_timer_unit_tb.sv -----
// Testbench for the multi-slot software timer unit: directed and random steps vs. a predictor.
`default_nettype none
module multi_slot_software_timer_unit_tb;

  localparam int SLOTS = 16;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [mstu_pkg::KIND_W-1:0] kind;
    logic [mstu_pkg::SLOT_W-1:0] fired_slot;
    logic [mstu_pkg::VAL_W-1:0]  dispatched_tag;
    logic [mstu_pkg::VAL_W-1:0]  next_delay;
    logic                        slot_active;
    logic                        last;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  mstu_req_if req ();
  mstu_rsp_if rsp ();

  multi_slot_software_timer_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // predictor state
  logic [31:0] tm_deadline [SLOTS];
  logic [31:0] tm_period [SLOTS];
  logic        tm_cyclic [SLOTS];
  logic        tm_active [SLOTS];
  logic        tm_armed [SLOTS];
  logic        tm_epoch [SLOTS];
  logic        cur_epoch;
  logic [31:0] last_now;

  timer_result_t expected_results [$];
  timer_result_t step_buf [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int fires_seen = 0;
  int wraps_sent = 0;
  int idle_cycles = 0;
  bit long_hold = 0;
  logic [31:0] tick_now = 0;

  function automatic void arm_slot(int s, logic [31:0] now);
    tm_deadline[s] = tm_deadline[s] + tm_period[s];
    tm_epoch[s] = (tm_deadline[s] < now) ? ~cur_epoch : cur_epoch;
    tm_armed[s] = 1'b1;
  endfunction

  function automatic void fire_slot(int s, logic [31:0] now);
    timer_result_t r;
    r = '0;
    r.kind = mstu_pkg::KIND_FIRE;
    r.fired_slot = s[mstu_pkg::SLOT_W-1:0];
    step_buf.push_back(r);
    if (!tm_cyclic[s]) tm_active[s] = 1'b0;
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (tm_armed[i] && tm_epoch[i] == cur_epoch)
        if (best < 0 || tm_deadline[i] < tm_deadline[best]) best = i;
    return best;
  endfunction

  function automatic void predict_step(logic [2:0] op, logic [3:0] slot, logic [31:0] per,
                                       logic [31:0] st, logic rep, logic stop,
                                       logic [31:0] now, logic [31:0] tag);
    logic [31:0] diff;
    logic old [SLOTS];
    timer_result_t r;
    int best, e, s;
    s = slot;
    step_buf.delete();
    if (per == 0) per = 1;
    if (op == mstu_pkg::OP_START) begin
      if (tm_armed[s]) begin
        tm_armed[s] = 1'b0;
        tm_active[s] = 1'b0;
      end
      tm_deadline[s] = st;
      tm_period[s] = per;
      tm_cyclic[s] = rep;
      tm_active[s] = 1'b1;
      diff = (now >= st) ? now - st : st - now;
      if (diff >= per) begin
        fire_slot(s, now);
        if (tm_cyclic[s]) begin
          tm_deadline[s] = now;
          arm_slot(s, now);
        end
      end else arm_slot(s, now);
    end else if (op == mstu_pkg::OP_CANCEL) begin
      if (tm_armed[s]) begin
        tm_armed[s] = 1'b0;
        tm_active[s] = 1'b0;
      end
    end else if (op == mstu_pkg::OP_MODIFY) begin
      if (stop) tm_cyclic[s] = 1'b0;
      else tm_period[s] = per;
    end else if (op == mstu_pkg::OP_DISPATCH) begin
      r = '0;
      r.kind = mstu_pkg::KIND_WORK;
      r.dispatched_tag = tag;
      step_buf.push_back(r);
    end
    if (now < last_now) begin
      for (int i = 0; i < SLOTS; i++) old[i] = tm_armed[i] && tm_epoch[i] == cur_epoch;
      cur_epoch = ~cur_epoch;
      forever begin
        best = -1;
        for (int i = 0; i < SLOTS; i++)
          if (old[i] && (best < 0 || tm_deadline[i] < tm_deadline[best])) best = i;
        if (best < 0) break;
        old[best] = 1'b0;
        tm_armed[best] = 1'b0;
        fire_slot(best, now);
        if (tm_cyclic[best]) begin
          tm_deadline[best] = now;
          arm_slot(best, now);
        end
      end
    end
    forever begin
      e = earliest_slot();
      if (e < 0 || tm_deadline[e] > now) break;
      tm_armed[e] = 1'b0;
      fire_slot(e, now);
      if (tm_cyclic[e]) begin
        tm_deadline[e] = now;
        arm_slot(e, now);
      end
    end
    e = earliest_slot();
    r = '0;
    r.kind = mstu_pkg::KIND_SUMMARY;
    r.next_delay = (e >= 0) ? tm_deadline[e] - now : 32'd0 - now;
    r.last = 1'b1;
    step_buf.push_back(r);
    last_now = now;
    foreach (step_buf[k]) begin
      step_buf[k].slot_active = tm_active[s];
      expected_results.push_back(step_buf[k]);
    end
  endfunction

  // sender burst/gap shaping
  int burst_left = 0;

  task automatic send_item(logic [2:0] op, logic [3:0] slot, logic [31:0] per,
                           logic [31:0] st, logic rep, logic stop,
                           logic [31:0] now, logic [31:0] tag);
    // valid was dropped at the previous accept; move to the next edge first
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 25)) @(posedge clk);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.op <= op;
    req.slot <= slot;
    req.period_ticks <= per;
    req.start_tick <= st;
    req.repeat_req <= rep;
    req.stop_repeat <= stop;
    req.now_tick <= now;
    req.work_tag <= tag;
    do @(posedge clk); while (!req.ready);
    predict_step(op, slot, per, st, rep, stop, now, tag);
    if (now < tick_now) wraps_sent++;
    tick_now = now;
    items_sent++;
    req.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else if (long_hold) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(0, 9) < 3) ? ((results_seen % 64) < 40) : 1'b1;
  end

  always @(posedge clk) begin
    timer_result_t got, exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.kind, rsp.fired_slot, rsp.dispatched_tag, rsp.next_delay,
              rsp.slot_active, rsp.last};
      results_seen++;
      if (got.kind == mstu_pkg::KIND_FIRE) fires_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          errors++;
          $display("%0t: mismatch expected kind=%0d slot=%0d tag=%h delay=%h act=%b last=%b",
                   $time, exp_r.kind, exp_r.fired_slot, exp_r.dispatched_tag,
                   exp_r.next_delay, exp_r.slot_active, exp_r.last);
          $display("%0t:          actual   kind=%0d slot=%0d tag=%h delay=%h act=%b last=%b",
                   $time, got.kind, got.fired_slot, got.dispatched_tag,
                   got.next_delay, got.slot_active, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT && !long_hold) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(mstu_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'd0, 0);
    send_item(mstu_pkg::OP_DISPATCH, 4'd15, '1, '1, 1, 1, 32'd5, 32'hFFFF_FFFF);
    send_item(mstu_pkg::OP_DISPATCH, 0, 0, 0, 0, 0, 32'd5, 32'h0000_0000);
    send_item(mstu_pkg::OP_START, 0, 32'd10, 32'd5, 0, 0, 32'd6, 0);       // one-shot armed
    send_item(mstu_pkg::OP_START, 4'd15, 32'd0, 32'd6, 1, 0, 32'd6, 0);    // period 0 -> 1
    send_item(mstu_pkg::OP_START, 4'd3, 32'd4, 32'd0, 1, 0, 32'd6, 0);     // overdue cyclic
    send_item(mstu_pkg::OP_START, 4'd4, 32'd20, 32'd100, 0, 0, 32'd6, 0);  // far ahead: fires
    send_item(mstu_pkg::OP_START, 4'd5, 32'd10, 32'd5, 0, 0, 32'd6, 0);    // ties slot 0
    send_item(mstu_pkg::OP_MODIFY, 4'd15, 32'd7, 0, 0, 0, 32'd7, 0);
    send_item(mstu_pkg::OP_MODIFY, 4'd3, 0, 0, 0, 1, 32'd8, 0);            // stop repeating
    send_item(mstu_pkg::OP_CANCEL, 4'd5, 0, 0, 0, 0, 32'd9, 0);
    send_item(mstu_pkg::OP_CANCEL, 4'd9, 0, 0, 0, 0, 32'd9, 0);            // not armed
    send_item(mstu_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'd15, 0);
    send_item(3'd5, 4'd1, 0, 0, 0, 0, 32'd16, 0);                          // undefined ops
    send_item(3'd7, 4'd2, 0, 0, 0, 0, 32'd17, 0);
    send_item(mstu_pkg::OP_START, 4'd6, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1, 0,
              32'hFFFF_FFF0, 0);
    send_item(mstu_pkg::OP_START, 4'd7, 32'd100, 32'hFFFF_FFF0, 1, 0,
              32'hFFFF_FFF8, 0);                                           // past wrap
    send_item(mstu_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'd3, 0);                 // wrap
    send_item(mstu_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send_item(mstu_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'd0, 0);                 // wrap again
    drain();
  endtask

  task automatic test_random(int n);
    logic [2:0] op;
    logic [31:0] step, per, st;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: op = mstu_pkg::OP_START;
        3: op = mstu_pkg::OP_CANCEL;
        4: op = mstu_pkg::OP_MODIFY;
        5: op = mstu_pkg::OP_DISPATCH;
        6: op = 3'($urandom_range(5, 7));
        default: op = mstu_pkg::OP_TICK;
      endcase
      step = ($urandom_range(0, 30) == 0) ? $urandom : $urandom_range(0, 40);
      per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
      st = ($urandom_range(0, 3) == 0) ? $urandom : tick_now + $urandom_range(0, 30) - 10;
      send_item(op, 4'($urandom), per, st, 1'($urandom), 1'($urandom),
                tick_now + step, $urandom);
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      test_random(12);
    join
    drain();
  endtask

  initial begin
    req.valid = 1'b0;
    req.op = mstu_pkg::OP_TICK;
    req.slot = '0;
    req.period_ticks = '0;
    req.start_tick = '0;
    req.repeat_req = 1'b0;
    req.stop_repeat = 1'b0;
    req.now_tick = '0;
    req.work_tag = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      tm_deadline[i] = 0; tm_period[i] = 0; tm_cyclic[i] = 0;
      tm_active[i] = 0; tm_armed[i] = 0; tm_epoch[i] = 0;
    end
    cur_epoch = 0;
    last_now = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(120);
    test_backpressure();
    test_random(120);
    drain();
    repeat (100) @(posedge clk);
    $display("run: %0d items sent, %0d results checked (%0d fires), %0d tick wraps",
             items_sent, results_seen, fires_seen, wraps_sent);
    if (errors == 0 && expected_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
design/mstu_pkg.sv
design/mstu_if.sv
design/mstu_evq.sv
design/multi_slot_software_timer_unit.sv
sim/multi_slot_software_timer_unit_tb.sv
